[design/lpr_pkg.sv]
// lpr_pkg: shared types, codes and helpers of the line pixel rasterizer
// used by line_pixel_rasterizer and lpr_checker; no dependencies
`default_nettype none

package lpr_pkg;

	localparam int COORD_BITS = 12;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_INDEX_BITS = 2;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_X_OFFSET = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_Y_OFFSET = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BYTES_PER_PIXEL = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_PITCH = 2'd3;

	localparam logic [11:0] X_OFFSET_RESET = 12'd0;
	localparam logic [11:0] Y_OFFSET_RESET = 12'd0;
	localparam logic [3:0] BYTES_PER_PIXEL_RESET = 4'd4;
	localparam logic [15:0] ROW_PITCH_RESET = 16'd4096;

	// input commands
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// stepping modes, low two bits of the mode register
	localparam logic [1:0] MODE_VERT = 2'd0;
	localparam logic [1:0] MODE_SHALLOW = 2'd1;
	localparam logic [1:0] MODE_STEEP = 2'd2;
	localparam int MODE_DOWN_BIT = 2;

	localparam logic [7:0] COLOR_WHITE = 8'd255;
	localparam logic [8:0] MOD_BASE = 9'd255;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COORD_BITS:0] wide_t;
	typedef logic signed [COORD_BITS+1:0] err_t;
	typedef logic [2:0] mode_t;

	typedef struct packed {
		logic command;
		coord_t x_start;
		coord_t y_start;
		coord_t x_end;
		coord_t y_end;
		logic colorful;
	} in_item_t;

	typedef struct packed {
		logic pixel_valid;
		coord_t pixel_x;
		coord_t pixel_y;
		logic [31:0] byte_address;
		logic [7:0] channel_one;
		logic [7:0] channel_two;
		logic [7:0] channel_three;
		logic last_pixel;
	} out_item_t;

	// low byte of the truncating remainder by 255 of a value given as sign and magnitude
	function automatic logic [7:0] rem255_byte(input logic neg, input logic [23:0] mag);
		logic [9:0] s1;
		logic [8:0] s2;
		logic [7:0] m;
		s1 = 10'(mag[7:0]) + 10'(mag[15:8]) + 10'(mag[23:16]);
		s2 = 9'(s1[7:0]) + 9'(s1[9:8]);
		m = (s2 >= MOD_BASE) ? 8'(s2 - MOD_BASE) : s2[7:0];
		return neg ? 8'(8'd0 - m) : m;
	endfunction

endpackage

`default_nettype wire

[design/line_pixel_rasterizer.sv]
// line_pixel_rasterizer: integer line stepping with address and color generation
// an accepted transaction goes to stage one, then to the output register once the output is free
// throughput: one transaction per cycle while not stalled; stepping updates on every accept
// the address multipliers sit in the second stage behind the stepping register
// reset: asynchronous, active low; ends the line, empties both stages, restores register defaults
// depends on lpr_pkg
`default_nettype none

module line_pixel_rasterizer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [lpr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input wire logic [lpr_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire lpr_pkg::in_item_t in_item,
	output logic out_valid,
	input wire logic out_stall,
	output lpr_pkg::out_item_t out_item
);
	import lpr_pkg::*;

	// configuration
	logic [11:0] x_offset_q;
	logic [11:0] y_offset_q;
	logic [3:0] bpp_q;
	logic [15:0] row_pitch_q;

	// line state
	logic line_active_q;
	coord_t cur_x_q, cur_y_q, final_major_q;
	wide_t delta_major_q, delta_minor_q;
	err_t err_q;
	mode_t mode_q;
	logic color_q;

	// stage one: emitted pixel
	logic v_s1, pv_s1, color_s1, last_s1;
	coord_t x_s1, y_s1;

	// stage two: output register
	logic out_valid_q;
	out_item_t out_item_q;

	logic out_free, s1_free, accept;

	// next-state signals
	logic swap;
	coord_t xa0, ya0, xa1, ya1;
	wide_t dx, yd, dy;
	logic steep;
	logic n_active, n_color, n_emit, n_last;
	coord_t n_x, n_y, n_fin;
	wide_t n_dmaj, n_dmin;
	err_t n_err, e1;
	mode_t n_mode;
	logic signed [COORD_BITS+2:0] e1x2;
	logic take;
	coord_t major;

	// stage two signals
	logic [31:0] ax, ay, addr;
	wide_t xw, yw, dw, xm, ym, dm;
	logic [7:0] c1, c2, c3;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_free = !v_s1 || out_free;
	assign in_stall = !s1_free;
	assign accept = in_valid && s1_free;

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset_q <= X_OFFSET_RESET;
			y_offset_q <= Y_OFFSET_RESET;
			bpp_q <= BYTES_PER_PIXEL_RESET;
			row_pitch_q <= ROW_PITCH_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_X_OFFSET: x_offset_q <= cfg_data[11:0];
				REG_Y_OFFSET: y_offset_q <= cfg_data[11:0];
				REG_BYTES_PER_PIXEL: bpp_q <= cfg_data[3:0];
				REG_ROW_PITCH: row_pitch_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// endpoint ordering and deltas
	always_comb begin
		swap = in_item.x_start > in_item.x_end;
		xa0 = swap ? in_item.x_end : in_item.x_start;
		ya0 = swap ? in_item.y_end : in_item.y_start;
		xa1 = swap ? in_item.x_start : in_item.x_end;
		ya1 = swap ? in_item.y_start : in_item.y_end;
		dx = wide_t'(xa1) - wide_t'(xa0);
		yd = wide_t'(ya1) - wide_t'(ya0);
		dy = (yd < 0) ? -yd : yd;
		steep = dy > dx;
	end

	// error term for a step
	assign e1 = err_q + err_t'(delta_minor_q);
	assign e1x2 = {e1, 1'b0};
	assign take = e1x2 >= (COORD_BITS+3)'(delta_major_q);

	always_comb begin
		n_active = line_active_q;
		n_color = color_q;
		n_x = cur_x_q;
		n_y = cur_y_q;
		n_fin = final_major_q;
		n_dmaj = delta_major_q;
		n_dmin = delta_minor_q;
		n_err = err_q;
		n_mode = mode_q;
		n_emit = 1'b0;
		if (in_item.command == CMD_START) begin
			n_emit = 1'b1;
			n_color = in_item.colorful;
			n_err = '0;
			n_x = xa0;
			if (dx == '0) begin
				n_mode = {1'b0, MODE_VERT};
				n_y = (ya0 < ya1) ? ya0 : ya1;
				n_fin = (ya0 < ya1) ? ya1 : ya0;
				n_dmaj = dy;
				n_dmin = '0;
			end else begin
				n_y = ya0;
				if (!steep) begin
					n_mode = {1'b0, MODE_SHALLOW};
					n_fin = xa1;
					n_dmaj = dx;
					n_dmin = dy;
				end else begin
					n_mode = {1'b0, MODE_STEEP};
					n_fin = ya1;
					n_dmaj = dy;
					n_dmin = dx;
				end
				n_mode[MODE_DOWN_BIT] = ya1 < ya0;
			end
		end else if (line_active_q) begin
			n_emit = 1'b1;
			case (mode_q[1:0])
				MODE_SHALLOW: begin
					if (take) begin
						n_y = mode_q[MODE_DOWN_BIT] ? cur_y_q - coord_t'(1) : cur_y_q + coord_t'(1);
						n_err = e1 - err_t'(delta_major_q);
					end else begin
						n_err = e1;
					end
					n_x = cur_x_q + coord_t'(1);
				end
				MODE_STEEP: begin
					if (take) begin
						n_x = cur_x_q + coord_t'(1);
						n_err = e1 - err_t'(delta_major_q);
					end else begin
						n_err = e1;
					end
					n_y = mode_q[MODE_DOWN_BIT] ? cur_y_q - coord_t'(1) : cur_y_q + coord_t'(1);
				end
				default: n_y = cur_y_q + coord_t'(1);
			endcase
		end
		major = (n_mode[1:0] == MODE_SHALLOW) ? n_x : n_y;
		n_last = n_emit && (major == n_fin);
		if (n_emit) begin
			n_active = !n_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q <= 1'b0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			final_major_q <= '0;
			delta_major_q <= '0;
			delta_minor_q <= '0;
			err_q <= '0;
			mode_q <= '0;
			color_q <= 1'b0;
		end else if (accept) begin
			line_active_q <= n_active;
			cur_x_q <= n_x;
			cur_y_q <= n_y;
			final_major_q <= n_fin;
			delta_major_q <= n_dmaj;
			delta_minor_q <= n_dmin;
			err_q <= n_err;
			mode_q <= n_mode;
			color_q <= n_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pv_s1 <= n_emit;
			x_s1 <= n_x;
			y_s1 <= n_y;
			color_s1 <= n_color;
			last_s1 <= n_last;
		end
	end

	// address and color of the stage one pixel
	always_comb begin
		ax = 32'(x_s1) + 32'(x_offset_q);
		ay = 32'(y_s1) + 32'(y_offset_q);
		addr = ax * 32'(bpp_q) + ay * 32'(row_pitch_q);
		xw = wide_t'(x_s1);
		yw = wide_t'(y_s1);
		dw = yw - xw;
		xm = (xw < 0) ? -xw : xw;
		ym = (yw < 0) ? -yw : yw;
		dm = (dw < 0) ? -dw : dw;
		c1 = rem255_byte(xw < 0, 24'(xm));
		c2 = rem255_byte(yw < 0, 24'(ym));
		c3 = rem255_byte(dw < 0, 24'(dm));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s1) begin
			if (pv_s1) begin
				out_item_q.pixel_valid <= 1'b1;
				out_item_q.pixel_x <= x_s1;
				out_item_q.pixel_y <= y_s1;
				out_item_q.byte_address <= addr;
				out_item_q.channel_one <= color_s1 ? c1 : COLOR_WHITE;
				out_item_q.channel_two <= color_s1 ? c2 : COLOR_WHITE;
				out_item_q.channel_three <= color_s1 ? c3 : COLOR_WHITE;
				out_item_q.last_pixel <= last_s1;
			end else begin
				out_item_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

[design/lpr_checker.sv]
// lpr_assertions: port-level assertions for line_pixel_rasterizer, bound to the top level
// depends on lpr_pkg and line_pixel_rasterizer
`default_nettype none

module lpr_assertions (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire lpr_pkg::out_item_t out_item
);
	import lpr_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_item))
		else $error("result payload changed while stalled");

	// a transaction with no active line gives an all-zero result
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.pixel_valid |-> out_item == '0)
		else $error("idle step result not zero");

	// the final pixel of a line is always a real pixel
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.last_pixel |-> out_item.pixel_valid)
		else $error("last pixel flagged without a pixel");

endmodule

bind line_pixel_rasterizer lpr_assertions u_lpr_assertions (.*);

`default_nettype wire

[sim/lpr_checker.sv]
// lpr_checker: watches both channels of the line rasterizer, predicts every pixel and compares
// keeps its own copy of the registers and of the line stepping state; depends on lpr_pkg
module lpr_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [lpr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [lpr_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input logic in_valid,
	input logic in_stall,
	input lpr_pkg::in_item_t in_item,
	input logic out_valid,
	input logic out_stall,
	input lpr_pkg::out_item_t out_item,
	output int failures,
	output int outstanding
);
	import lpr_pkg::*;

	logic [11:0] x_offset = X_OFFSET_RESET;
	logic [11:0] y_offset = Y_OFFSET_RESET;
	logic [3:0] bytes_per_pixel = BYTES_PER_PIXEL_RESET;
	logic [15:0] row_pitch = ROW_PITCH_RESET;

	bit drawing = 1'b0;
	int pen_x = 0;
	int pen_y = 0;
	int stop_major = 0;
	int run_major = 0;
	int run_minor = 0;
	int slack = 0;
	mode_t mode = '0;
	bit tinted = 1'b0;

	out_item_t pixels_due[$];
	out_item_t want_px;
	int mismatches = 0;
	int due_count = 0;

	assign failures = mismatches;
	assign outstanding = due_count;

	function automatic out_item_t plot_pixel(bit last);
		out_item_t px;
		logic [31:0] ax;
		logic [31:0] ay;
		ax = 32'(pen_x + int'(x_offset));
		ay = 32'(pen_y + int'(y_offset));
		px.pixel_valid = 1'b1;
		px.pixel_x = coord_t'(pen_x);
		px.pixel_y = coord_t'(pen_y);
		px.byte_address = ax * 32'(bytes_per_pixel) + ay * 32'(row_pitch);
		if (tinted) begin
			px.channel_one = 8'(pen_x % int'(MOD_BASE));
			px.channel_two = 8'(pen_y % int'(MOD_BASE));
			px.channel_three = 8'((pen_y - pen_x) % int'(MOD_BASE));
		end else begin
			px.channel_one = COLOR_WHITE;
			px.channel_two = COLOR_WHITE;
			px.channel_three = COLOR_WHITE;
		end
		px.last_pixel = last;
		return px;
	endfunction

	// one transaction in, the pixel it should produce out
	task automatic rasterize(input in_item_t it, output out_item_t px);
		int x0, y0, x1, y1, dx, dy;
		bit last;
		px = '0;
		if (it.command == CMD_START) begin
			x0 = it.x_start;
			y0 = it.y_start;
			x1 = it.x_end;
			y1 = it.y_end;
			if (x0 > x1) begin
				dx = x0; x0 = x1; x1 = dx;
				dy = y0; y0 = y1; y1 = dy;
			end
			tinted = it.colorful;
			dx = x1 - x0;
			dy = (y1 >= y0) ? y1 - y0 : y0 - y1;
			slack = 0;
			drawing = 1'b1;
			if (dx == 0) begin
				mode = {1'b0, MODE_VERT};
				pen_x = x0;
				pen_y = (y0 < y1) ? y0 : y1;
				stop_major = (y0 < y1) ? y1 : y0;
				run_major = dy;
				run_minor = 0;
			end else begin
				pen_x = x0;
				pen_y = y0;
				if (dy <= dx) begin
					mode = {1'b0, MODE_SHALLOW};
					stop_major = x1;
					run_major = dx;
					run_minor = dy;
				end else begin
					mode = {1'b0, MODE_STEEP};
					stop_major = y1;
					run_major = dy;
					run_minor = dx;
				end
				mode[MODE_DOWN_BIT] = (y1 < y0);
			end
		end else if (drawing) begin
			case (mode[1:0])
				MODE_SHALLOW: begin
					slack += run_minor;
					if (slack * 2 >= run_major) begin
						pen_y += mode[MODE_DOWN_BIT] ? -1 : 1;
						slack -= run_major;
					end
					pen_x += 1;
				end
				MODE_STEEP: begin
					slack += run_minor;
					if (slack * 2 >= run_major) begin
						pen_x += 1;
						slack -= run_major;
					end
					pen_y += mode[MODE_DOWN_BIT] ? -1 : 1;
				end
				default: pen_y += 1;
			endcase
		end
		if (drawing) begin
			last = ((mode[1:0] == MODE_SHALLOW) ? pen_x : pen_y) == stop_major;
			px = plot_pixel(last);
			if (last)
				drawing = 1'b0;
		end
	endtask

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset = X_OFFSET_RESET;
			y_offset = Y_OFFSET_RESET;
			bytes_per_pixel = BYTES_PER_PIXEL_RESET;
			row_pitch = ROW_PITCH_RESET;
			drawing = 1'b0;
			pen_x = 0;
			pen_y = 0;
			stop_major = 0;
			run_major = 0;
			run_minor = 0;
			slack = 0;
			mode = '0;
			tinted = 1'b0;
			pixels_due.delete();
			due_count = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_X_OFFSET: x_offset = cfg_data[11:0];
					REG_Y_OFFSET: y_offset = cfg_data[11:0];
					REG_BYTES_PER_PIXEL: bytes_per_pixel = cfg_data[3:0];
					REG_ROW_PITCH: row_pitch = cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pixels_due.size() == 0) begin
					$error("pixel transaction with no expectation pending");
					mismatches++;
				end else begin
					want_px = pixels_due.pop_front();
					compare_field("pixel_valid", want_px.pixel_valid, out_item.pixel_valid);
					compare_field("pixel_x", want_px.pixel_x, out_item.pixel_x);
					compare_field("pixel_y", want_px.pixel_y, out_item.pixel_y);
					compare_field("byte_address", want_px.byte_address, out_item.byte_address);
					compare_field("channel_one", want_px.channel_one, out_item.channel_one);
					compare_field("channel_two", want_px.channel_two, out_item.channel_two);
					compare_field("channel_three", want_px.channel_three,
						out_item.channel_three);
					compare_field("last_pixel", want_px.last_pixel, out_item.last_pixel);
				end
			end
			if (in_valid && !in_stall) begin
				rasterize(in_item, want_px);
				pixels_due.push_back(want_px);
			end
			due_count = pixels_due.size();
		end
	end

endmodule

[sim/tb_line_pixel_rasterizer.sv]
// tb_line_pixel_rasterizer: drives line start and step transactions into line_pixel_rasterizer
// under random gaps and stalls, across several register settings; lpr_checker judges the pixels
// depends on lpr_pkg, line_pixel_rasterizer and lpr_checker
module tb_line_pixel_rasterizer;
	import lpr_pkg::*;

	localparam int ITEMS_PER_PHASE = 300;
	localparam int PHASES = 6;
	localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
	localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = REG_X_OFFSET;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	int failures;
	int outstanding;
	int stall_hold = 0;
	bit eager = 1'b0;
	int items_done = 0;

	always #4 clk = ~clk;

	line_pixel_rasterizer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	lpr_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.failures(failures),
		.outstanding(outstanding)
	);

	// receiver back-pressure: runs of free and stalled cycles, mostly short
	always @(posedge clk) begin
		if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else if (out_stall) begin
			out_stall <= 1'b0;
			stall_hold <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 6);
		end else begin
			out_stall <= 1'b1;
			stall_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 2);
		end
	end

	initial begin
		#8000000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic offer(input in_item_t it);
		int pick;
		int gap;
		pick = $urandom_range(0, 99);
		gap = 0;
		if (!eager) begin
			if (pick >= 97)
				gap = $urandom_range(20, 40);
			else if (pick >= 90)
				gap = $urandom_range(4, 10);
			else if (pick >= 55)
				gap = $urandom_range(1, 3);
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
	endtask

	// start transaction, then a number of step transactions carrying random unused fields
	task automatic run_line(input int x0, input int y0, input int x1,
		input int y1, input logic colorful, input int steps);
		in_item_t it;
		logic [63:0] noise;
		it.command = CMD_START;
		it.x_start = coord_t'(x0);
		it.y_start = coord_t'(y0);
		it.x_end = coord_t'(x1);
		it.y_end = coord_t'(y1);
		it.colorful = colorful;
		offer(it);
		repeat (steps) begin
			noise = {$urandom, $urandom};
			it = noise[$bits(in_item_t)-1:0];
			it.command = CMD_STEP;
			offer(it);
		end
	endtask

	task automatic load_config(input logic [11:0] x_off, input logic [11:0] y_off,
		input logic [3:0] bpp, input logic [15:0] row_bytes);
		cfg_write <= 1'b1;
		cfg_index <= REG_X_OFFSET;
		cfg_data <= CFG_DATA_BITS'(x_off);
		@(posedge clk);
		cfg_index <= REG_Y_OFFSET;
		cfg_data <= CFG_DATA_BITS'(y_off);
		@(posedge clk);
		cfg_index <= REG_BYTES_PER_PIXEL;
		cfg_data <= CFG_DATA_BITS'(bpp);
		@(posedge clk);
		cfg_index <= REG_ROW_PITCH;
		cfg_data <= row_bytes;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic int clamp_coord(int v);
		if (v < COORD_MIN)
			return COORD_MIN;
		if (v > COORD_MAX)
			return COORD_MAX;
		return v;
	endfunction

	initial begin
		int x0, y0, x1, y1, reach, shape, len, steps;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// single point, then a step with no line active
		run_line(0, 0, 0, 0, 1'b1, 1);
		// vertical given top-down, one step past its end
		run_line(5, 2, 5, -1, 1'b1, 4);
		run_line(-3, 1, 2, -1, 1'b0, 5);
		// steep, swapped endpoints, abandoned
		run_line(2, -2, 0, 3, 1'b1, 2);
		run_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1, 2);
		run_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1'b1, 1);
		run_line(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, 1'b0, 1);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: load_config(12'hFFF, 12'hFFF, 4'hF, 16'hFFFF);
				1: load_config('0, '0, '0, '0);
				2: load_config('0, '0, 4'd1, 16'd1);
				3: load_config(12'($urandom), 12'($urandom), 4'd8, 16'($urandom));
				4: load_config(12'($urandom), 12'($urandom), 4'($urandom), 16'($urandom));
				default: load_config(12'($urandom), 12'($urandom), BYTES_PER_PIXEL_RESET,
					ROW_PITCH_RESET);
			endcase
			items_done = 0;
			while (items_done < ITEMS_PER_PHASE) begin
				shape = $urandom_range(0, 99);
				reach = (shape < 80) ? 12 : (shape < 95) ? 120 : 4095;
				x0 = int'($urandom_range(0, 4095)) + COORD_MIN;
				y0 = int'($urandom_range(0, 4095)) + COORD_MIN;
				x1 = clamp_coord(x0 + int'($urandom_range(0, 2 * reach)) - reach);
				y1 = clamp_coord(y0 + int'($urandom_range(0, 2 * reach)) - reach);
				case ($urandom_range(0, 9))
					0: x1 = x0;
					1: y1 = y0;
					2: y1 = clamp_coord(y0 + (($urandom_range(0, 1) != 0) ? x1 - x0 : x0 - x1));
					default: ;
				endcase
				len = (x1 > x0) ? x1 - x0 : x0 - x1;
				len = ((y1 > y0) ? y1 - y0 : y0 - y1) > len ? ((y1 > y0) ? y1 - y0 : y0 - y1)
					: len;
				len = len + 1;
				shape = $urandom_range(0, 99);
				if (len > 200)
					steps = $urandom_range(0, 20);
				else if (shape < 78)
					steps = len - 1;
				else if (shape < 90)
					steps = $urandom_range(0, len - 1);
				else
					steps = len - 1 + $urandom_range(1, 3);
				eager = ($urandom_range(0, 4) == 0);
				run_line(x0, y0, x1, y1, 1'($urandom), steps);
				items_done += 1 + ((steps < len) ? steps : len - 1);
			end
			eager = 1'b0;
		end
		settle();

		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
design/lpr_pkg.sv
design/line_pixel_rasterizer.sv
design/lpr_checker.sv
sim/lpr_checker.sv
sim/tb_line_pixel_rasterizer.sv
